>>> rtl/core/mvsd_pkg.sv
`default_nettype none

package mvsd_pkg;

  // Default sizes of the sample counter range and of the gap timers.
  localparam int unsigned MaxSamplesDef = 15;
  localparam int unsigned GapBitsDef    = 16;

  // Widths of the configuration fields and of the port.
  localparam int unsigned SampW     = 4;
  localparam int unsigned GapCfgW   = 16;
  localparam int unsigned ReadW     = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgSamplesPerRead   = 3'd0,
    CfgActiveMinSamples = 3'd1,
    CfgSampleGapTicks   = 3'd2,
    CfgReadGapTicks     = 3'd3,
    CfgStableReadsNeed  = 3'd4,
    CfgMaxReads         = 3'd5,
    CfgActiveLevel      = 3'd6
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [SampW-1:0]   RstSamplesPerRead   = 4'd5;
  localparam logic [SampW-1:0]   RstActiveMinSamples = 4'd3;
  localparam logic [GapCfgW-1:0] RstSampleGapTicks   = 16'd10;
  localparam logic [GapCfgW-1:0] RstReadGapTicks     = 16'd10;
  localparam logic [ReadW-1:0]   RstStableReadsNeed  = 8'd3;
  localparam logic [ReadW-1:0]   RstMaxReads         = 8'd10;
  localparam logic               RstActiveLevel      = 1'b0;

endpackage

`default_nettype wire

>>> rtl/core/majority_vote_stability_debouncer.sv
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid_i/in_ready_o   | start_req_i, pin_level_i (one tick)
// out     | output    | out_valid_o/out_ready_i | qualified_level_o, data_value_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One tick word is taken every cycle while in_ready_o is high; its whole update
// happens in the cycle that accepts it, and a finishing tick's result is registered.
// The result side has an output register plus one skid entry, so ticks keep
// flowing while one result waits; in_ready_o drops only when both are full.
// Reset (rst_ni low, asynchronous) returns to idle with default registers.
// Configuration writes are always ready and take effect on the next tick.
`default_nettype none

module majority_vote_stability_debouncer #(
  parameter int unsigned MAX_SAMPLES = mvsd_pkg::MaxSamplesDef,
  parameter int unsigned GAP_BITS    = mvsd_pkg::GapBitsDef
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire                             start_req_i,
  input  wire                             pin_level_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            qualified_level_o,
  output logic                            data_value_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [mvsd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [mvsd_pkg::CfgDataW-1:0]   cfg_data_i
);

  import mvsd_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhWaitSample,
    PhWaitRead
  } phase_e;

  localparam logic [SampW-1:0] SampSat = {SampW{1'b1}};
  localparam logic [SampW-1:0] MaxSamp =
    (MAX_SAMPLES > 15) ? SampSat : SampW'(MAX_SAMPLES);
  localparam logic [ReadW-1:0] RunSat  = {ReadW{1'b1}};

  // Gap value as loaded into the timer: low GAP_BITS bits, zero means one.
  function automatic logic [GAP_BITS-1:0] load_gap(input logic [GapCfgW-1:0] g);
    logic [31:0]         w;
    logic [GAP_BITS-1:0] v;
    w = 32'(g);
    v = w[GAP_BITS-1:0];
    return (v == '0) ? GAP_BITS'(1) : v;
  endfunction

  // Configuration registers.
  logic [SampW-1:0]   spr_q, ams_q;
  logic [GapCfgW-1:0] sgap_q, rgap_q;
  logic [ReadW-1:0]   srn_q, maxr_q;
  logic               act_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q  <= RstSamplesPerRead;
      ams_q  <= RstActiveMinSamples;
      sgap_q <= RstSampleGapTicks;
      rgap_q <= RstReadGapTicks;
      srn_q  <= RstStableReadsNeed;
      maxr_q <= RstMaxReads;
      act_q  <= RstActiveLevel;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSamplesPerRead:   spr_q  <= cfg_data_i[SampW-1:0];
        CfgActiveMinSamples: ams_q  <= cfg_data_i[SampW-1:0];
        CfgSampleGapTicks:   sgap_q <= cfg_data_i;
        CfgReadGapTicks:     rgap_q <= cfg_data_i;
        CfgStableReadsNeed:  srn_q  <= cfg_data_i[ReadW-1:0];
        CfgMaxReads:         maxr_q <= cfg_data_i[ReadW-1:0];
        CfgActiveLevel:      act_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Qualification state.
  phase_e              phase_q, phase_d;
  logic [GAP_BITS-1:0] gc_q, gc_d;
  logic [SampW-1:0]    sidx_q, sidx_d, low_q, low_d;
  logic [ReadW-1:0]    ridx_q, ridx_d, run_q, run_d;
  logic                lv_q, lv_d;

  logic                in_fire, done;
  logic [SampW-1:0]    eff_samp, sidx_b, low_b, sidx_n, low_n;
  logic [ReadW-1:0]    ridx_b, run_b, ridx_n, run_inc;
  logic                lv_b, take, vote;
  logic [GAP_BITS-1:0] gc_dec;

  assign in_fire = in_valid_i & in_ready_o;

  // Effective samples per read: zero counts as one, clamped to the maximum.
  always_comb begin
    eff_samp = (spr_q == '0) ? SampW'(1) : spr_q;
    if (eff_samp > MaxSamp) eff_samp = MaxSamp;
  end

  // One tick of the sequencer: timer, sample, read completion and finish.
  always_comb begin
    phase_d = phase_q;
    gc_d    = gc_q;
    sidx_d  = sidx_q;
    low_d   = low_q;
    ridx_d  = ridx_q;
    run_d   = run_q;
    lv_d    = lv_q;
    done    = 1'b0;
    take    = 1'b0;
    sidx_b  = sidx_q;
    low_b   = low_q;
    ridx_b  = ridx_q;
    run_b   = run_q;
    lv_b    = lv_q;
    gc_dec  = (gc_q != '0) ? gc_q - GAP_BITS'(1) : '0;

    if (phase_q == PhIdle) begin
      if (start_req_i) begin
        take   = 1'b1;
        sidx_b = '0;
        low_b  = '0;
        ridx_b = '0;
        run_b  = '0;
        lv_b   = 1'b0;
      end
    end else begin
      gc_d = gc_dec;
      take = (gc_dec == '0);
    end

    low_n   = (!pin_level_i && low_b != SampSat) ? low_b + SampW'(1) : low_b;
    sidx_n  = sidx_b + SampW'(1);
    vote    = (low_n >= ams_q) ? 1'b0 : 1'b1;
    ridx_n  = ridx_b + ReadW'(1);
    run_inc = (run_b != RunSat) ? run_b + ReadW'(1) : run_b;

    if (take) begin
      ridx_d = ridx_b;
      run_d  = run_b;
      lv_d   = lv_b;
      if (sidx_n >= eff_samp) begin
        // The read is complete: vote and update the run of equal votes.
        ridx_d = ridx_n;
        if (ridx_n == ReadW'(1)) begin
          lv_d  = vote;
          run_d = ReadW'(1);
        end else if (vote == lv_b) begin
          run_d = run_inc;
          if (run_inc >= srn_q) done = 1'b1;
        end else begin
          lv_d  = vote;
          run_d = ReadW'(1);
        end
        if (ridx_n >= maxr_q) done = 1'b1;
        sidx_d = '0;
        low_d  = '0;
        if (done) begin
          phase_d = PhIdle;
          gc_d    = '0;
        end else begin
          phase_d = PhWaitRead;
          gc_d    = load_gap(rgap_q);
        end
      end else begin
        sidx_d  = sidx_n;
        low_d   = low_n;
        phase_d = PhWaitSample;
        gc_d    = load_gap(sgap_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      gc_q    <= '0;
      sidx_q  <= '0;
      low_q   <= '0;
      ridx_q  <= '0;
      run_q   <= '0;
      lv_q    <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      gc_q    <= gc_d;
      sidx_q  <= sidx_d;
      low_q   <= low_d;
      ridx_q  <= ridx_d;
      run_q   <= run_d;
      lv_q    <= lv_d;
    end
  end

  // Result register with one skid entry behind it.
  logic push, pop;
  logic out_vld_q, out_lvl_q, out_dat_q;
  logic skid_vld_q, skid_lvl_q, skid_dat_q;

  assign push       = in_fire & done;
  assign pop        = out_vld_q & out_ready_i;
  assign in_ready_o = ~skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || pop) begin
      out_vld_q <= push;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_lvl_q <= skid_lvl_q;
        out_dat_q <= skid_dat_q;
      end
    end else if (!out_vld_q || pop) begin
      if (push) begin
        out_lvl_q <= lv_d;
        out_dat_q <= (lv_d == act_q);
      end
    end else if (push) begin
      skid_lvl_q <= lv_d;
      skid_dat_q <= (lv_d == act_q);
    end
  end

  assign out_valid_o       = out_vld_q;
  assign qualified_level_o = out_lvl_q;
  assign data_value_o      = out_dat_q;

endmodule

`default_nettype wire

>>> rtl/core/mvsd_checker.sv
`default_nettype none

module mvsd_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid_i,
  input wire                           in_ready_o,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input wire                           qualified_level_o,
  input wire                           data_value_o
);

  // A waiting result word is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A waiting result word keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(qualified_level_o) && $stable(data_value_o))
    else $error("result word changed while stalled");

  // A new result appears only right after a tick word was accepted.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result word without an accepted tick");

  // Input backpressure only happens while a result is waiting.
  a_ready_why: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // With the output stalled, a full buffer stays full.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
    else $error("buffer emptied without a result taken");

endmodule

bind majority_vote_stability_debouncer mvsd_checker u_mvsd_checker (.*);

`default_nettype wire
